[rtl/core/hcb_pkg.sv]
`default_nettype none
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 32;
  localparam int FREQ_BITS_DEF   = 16;
  localparam int CODE_W          = 31;
  localparam int LEN_W           = 5;
  localparam int DEPTH_W         = 7;
  localparam int SYM_W           = 8;
  localparam int FREQ_IN_W       = 16;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_LOAD  = 5'd0;
  localparam logic [OP_W-1:0] OP_BINIT = 5'd1;
  localparam logic [OP_W-1:0] OP_SDX   = 5'd2;
  localparam logic [OP_W-1:0] OP_SDXW  = 5'd3;
  localparam logic [OP_W-1:0] OP_SDL   = 5'd4;
  localparam logic [OP_W-1:0] OP_SDR   = 5'd5;
  localparam logic [OP_W-1:0] OP_SDC   = 5'd6;
  localparam logic [OP_W-1:0] OP_BNEXT = 5'd7;
  localparam logic [OP_W-1:0] OP_MCHK  = 5'd8;
  localparam logic [OP_W-1:0] OP_TK0   = 5'd9;
  localparam logic [OP_W-1:0] OP_TK1   = 5'd10;
  localparam logic [OP_W-1:0] OP_TKX   = 5'd11;
  localparam logic [OP_W-1:0] OP_INS   = 5'd12;
  localparam logic [OP_W-1:0] OP_INR   = 5'd13;
  localparam logic [OP_W-1:0] OP_INC   = 5'd14;
  localparam logic [OP_W-1:0] OP_INZ   = 5'd15;
  localparam logic [OP_W-1:0] OP_RT0   = 5'd16;
  localparam logic [OP_W-1:0] OP_RT1   = 5'd17;
  localparam logic [OP_W-1:0] OP_VIS   = 5'd18;
  localparam logic [OP_W-1:0] OP_OUTL  = 5'd19;
  localparam logic [OP_W-1:0] OP_CH    = 5'd20;
  localparam logic [OP_W-1:0] OP_OUT   = 5'd21;
  localparam logic [OP_W-1:0] OP_POP   = 5'd22;
  localparam logic [OP_W-1:0] OP_POPW  = 5'd23;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            take_b;
  } cmd_t;

  typedef struct packed {
    logic in_last_acc;
    logic cnt_ge2;
    logic cnt_gt1;
    logic best_is_x;
    logic i_zero;
    logic pos_zero;
    logic parent_gt;
    logic is_leaf;
    logic out_acc;
    logic out_last;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/hcb_ctrl.sv]
`default_nettype none
module hcb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hcb_pkg::stat_t st,
  output hcb_pkg::cmd_t      cmd
);
  import hcb_pkg::*;

  localparam logic [1:0] RET_BUILD = 2'd0;
  localparam logic [1:0] RET_TAKEA = 2'd1;
  localparam logic [1:0] RET_TAKEB = 2'd2;

  logic [OP_W-1:0] state_r, state_nxt;
  logic [1:0]      ret_r, ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      OP_LOAD:  if (st.in_last_acc) state_nxt = OP_BINIT;
      OP_BINIT: begin
        ret_nxt   = RET_BUILD;
        state_nxt = st.cnt_ge2 ? OP_SDX : OP_MCHK;
      end
      OP_SDX:   state_nxt = OP_SDXW;
      OP_SDXW:  state_nxt = OP_SDL;
      OP_SDL:   state_nxt = OP_SDR;
      OP_SDR:   state_nxt = OP_SDC;
      OP_SDC: begin
        if (!st.best_is_x) begin
          state_nxt = OP_SDL;
        end else begin
          case (ret_r)
            RET_BUILD: state_nxt = st.i_zero ? OP_MCHK : OP_BNEXT;
            RET_TAKEA: begin
              ret_nxt   = RET_TAKEB;
              state_nxt = OP_TK0;
            end
            default:   state_nxt = OP_INS;
          endcase
        end
      end
      OP_BNEXT: state_nxt = OP_SDX;
      OP_MCHK: begin
        if (st.cnt_gt1) begin
          ret_nxt   = RET_TAKEA;
          state_nxt = OP_TK0;
        end else begin
          state_nxt = OP_RT0;
        end
      end
      OP_TK0:   state_nxt = OP_TK1;
      OP_TK1:   state_nxt = OP_TKX;
      OP_TKX:   state_nxt = OP_SDL;
      OP_INS:   state_nxt = OP_INR;
      OP_INR:   state_nxt = st.pos_zero ? OP_INZ : OP_INC;
      OP_INC:   state_nxt = st.parent_gt ? OP_INR : OP_MCHK;
      OP_INZ:   state_nxt = OP_MCHK;
      OP_RT0:   state_nxt = OP_RT1;
      OP_RT1:   state_nxt = OP_VIS;
      OP_VIS:   state_nxt = st.is_leaf ? OP_OUTL : OP_CH;
      OP_OUTL:  state_nxt = OP_OUT;
      OP_CH:    state_nxt = OP_VIS;
      OP_OUT:   if (st.out_acc) state_nxt = st.out_last ? OP_LOAD : OP_POP;
      OP_POP:   state_nxt = OP_POPW;
      OP_POPW:  state_nxt = OP_VIS;
      default:  state_nxt = OP_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_LOAD;
      ret_r   <= RET_BUILD;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign cmd.op     = state_r;
  assign cmd.take_b = (ret_r == RET_TAKEB);

endmodule
`default_nettype wire

[rtl/core/hcb_datapath.sv]
`default_nettype none
module hcb_datapath #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
  parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire hcb_pkg::cmd_t          cmd,
  output hcb_pkg::stat_t              st,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [23:0]            in_tdata,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [47:0]                 out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);
  import hcb_pkg::*;

  localparam int NS  = 2 * MAX_SYMBOLS;
  localparam int NW  = $clog2(NS);
  localparam int HAW = $clog2(MAX_SYMBOLS);
  localparam int CW  = $clog2(MAX_SYMBOLS + 1);
  localparam int WW  = FREQ_BITS + $clog2(MAX_SYMBOLS);
  localparam int EW  = NW + WW;
  localparam int SEW = NW + CODE_W + DEPTH_W;
  localparam int PW  = HAW + 2;

  // heap entry: node index above weight
  logic [EW-1:0]  heap_mem [MAX_SYMBOLS];
  logic [SYM_W-1:0] sym_mem [MAX_SYMBOLS];
  logic [NW-1:0]  lc_mem [NS];
  logic [NW-1:0]  rc_mem [NS];
  logic [SEW-1:0] stk_mem [MAX_SYMBOLS];

  logic [EW-1:0]  hrd_r;
  logic [SYM_W-1:0] srd_r;
  logic [NW-1:0]  lrd_r, rrd_r;
  logic [SEW-1:0] krd_r;

  logic [CW-1:0]  cnt_r, n_r, sp_r;
  logic           ovf_r;
  logic [HAW-1:0] pos_r, i_r;
  logic [EW-1:0]  x_r, l_r, a_r, b_r, y_r;
  logic [NW-1:0]  next_r;
  logic [NW-1:0]  cur_node_r;
  logic [CODE_W-1:0]  cur_code_r;
  logic [DEPTH_W-1:0] cur_dep_r;
  logic [SYM_W-1:0]   osym_r;
  logic [CODE_W-1:0]  ocode_r;
  logic [LEN_W-1:0]   olen_r;
  logic               olast_r, oovf_r;

  logic           in_acc, out_acc;
  logic [63:0]    f64;
  logic [WW-1:0]  fw;
  logic [PW-1:0]  lpos, rpos;
  logic           l_ok, r_ok;
  logic [EW-1:0]  best;
  logic [HAW-1:0] bestpos;
  logic           best_x;
  logic [HAW-1:0] parent;
  logic           h_we;
  logic [HAW-1:0] h_wa, h_ra;
  logic [EW-1:0]  h_wd;
  logic [HAW-1:0] k_ra;

  assign in_tready  = (cmd.op == OP_LOAD);
  assign out_tvalid = (cmd.op == OP_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  assign f64 = {48'd0, in_tdata[23:8]} & ((64'd1 << FREQ_BITS) - 64'd1);
  assign fw  = WW'(f64);

  assign lpos   = {1'b0, pos_r, 1'b1};
  assign rpos   = PW'({1'b0, pos_r, 1'b0}) + PW'(2);
  assign l_ok   = lpos < PW'(cnt_r);
  assign r_ok   = rpos < PW'(cnt_r);
  assign parent = HAW'((pos_r - 1'b1) >> 1);

  // strict compares, left child wins ties
  always_comb begin
    best    = x_r;
    bestpos = pos_r;
    best_x  = 1'b1;
    if (l_ok && (l_r[WW-1:0] < best[WW-1:0])) begin
      best    = l_r;
      bestpos = lpos[HAW-1:0];
      best_x  = 1'b0;
    end
    if (r_ok && (hrd_r[WW-1:0] < best[WW-1:0])) begin
      best    = hrd_r;
      bestpos = rpos[HAW-1:0];
      best_x  = 1'b0;
    end
  end

  always_comb begin
    h_we = 1'b0;
    h_wa = pos_r;
    h_wd = best;
    h_ra = pos_r;
    case (cmd.op)
      OP_LOAD: begin
        h_we = in_acc && (cnt_r < CW'(MAX_SYMBOLS));
        h_wa = cnt_r[HAW-1:0];
        h_wd = {NW'(cnt_r), fw};
      end
      OP_SDX:  h_ra = i_r;
      OP_SDL:  h_ra = lpos[HAW-1:0];
      OP_SDR:  h_ra = rpos[HAW-1:0];
      OP_SDC:  h_we = 1'b1;
      OP_TK0:  h_ra = '0;
      OP_TK1:  h_ra = HAW'(cnt_r - 1'b1);
      OP_INR:  h_ra = parent;
      OP_INC: begin
        h_we = 1'b1;
        h_wd = (hrd_r[WW-1:0] > y_r[WW-1:0]) ? hrd_r : y_r;
      end
      OP_INZ: begin
        h_we = 1'b1;
        h_wa = '0;
        h_wd = y_r;
      end
      OP_RT0:  h_ra = '0;
      default: h_ra = pos_r;
    endcase
  end

  assign k_ra = HAW'(sp_r - 1'b1);

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    hrd_r <= heap_mem[h_ra];
    if (cmd.op == OP_LOAD && in_acc && (cnt_r < CW'(MAX_SYMBOLS)))
      sym_mem[cnt_r[HAW-1:0]] <= in_tdata[7:0];
    srd_r <= sym_mem[cur_node_r[HAW-1:0]];
    if (cmd.op == OP_INS) begin
      lc_mem[next_r] <= a_r[EW-1:WW];
      rc_mem[next_r] <= b_r[EW-1:WW];
    end
    lrd_r <= lc_mem[cur_node_r];
    rrd_r <= rc_mem[cur_node_r];
    if (cmd.op == OP_CH)
      stk_mem[sp_r[HAW-1:0]] <= {rrd_r, cur_code_r[CODE_W-2:0], 1'b1, cur_dep_r + 1'b1};
    krd_r <= stk_mem[k_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: if (in_acc) begin
          if (cnt_r < CW'(MAX_SYMBOLS)) cnt_r <= cnt_r + 1'b1;
          else ovf_r <= 1'b1;
        end
        OP_TKX:  cnt_r <= cnt_r - 1'b1;
        OP_INS:  cnt_r <= cnt_r + 1'b1;
        OP_OUT: if (out_acc && olast_r) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BINIT: begin
        n_r    <= cnt_r;
        next_r <= NW'(cnt_r);
        i_r    <= HAW'((cnt_r - 2'd2) >> 1);
      end
      OP_SDX:   pos_r <= i_r;
      OP_SDXW:  x_r <= hrd_r;
      OP_SDR:   l_r <= hrd_r;
      OP_SDC:   if (!best_x) pos_r <= bestpos;
      OP_BNEXT: i_r <= i_r - 1'b1;
      OP_TK1: begin
        if (cmd.take_b) b_r <= hrd_r;
        else a_r <= hrd_r;
      end
      OP_TKX: begin
        x_r   <= hrd_r;
        pos_r <= '0;
      end
      OP_INS: begin
        y_r   <= {next_r, a_r[WW-1:0] + b_r[WW-1:0]};
        pos_r <= HAW'(cnt_r);
      end
      OP_INC: begin
        if (hrd_r[WW-1:0] > y_r[WW-1:0]) pos_r <= parent;
        else next_r <= next_r + 1'b1;
      end
      OP_INZ:   next_r <= next_r + 1'b1;
      OP_RT1: begin
        cur_node_r <= hrd_r[EW-1:WW];
        cur_code_r <= '0;
        cur_dep_r  <= '0;
        sp_r       <= '0;
      end
      OP_OUTL: begin
        osym_r  <= srd_r;
        ocode_r <= cur_code_r;
        olen_r  <= (cur_dep_r > DEPTH_W'(31)) ? LEN_W'(31) : cur_dep_r[LEN_W-1:0];
        olast_r <= (sp_r == '0);
        oovf_r  <= ovf_r;
      end
      OP_CH: begin
        cur_node_r <= lrd_r;
        cur_code_r <= {cur_code_r[CODE_W-2:0], 1'b0};
        cur_dep_r  <= cur_dep_r + 1'b1;
        sp_r       <= sp_r + 1'b1;
      end
      OP_POP:   sp_r <= sp_r - 1'b1;
      OP_POPW: begin
        cur_node_r <= krd_r[SEW-1:CODE_W+DEPTH_W];
        cur_code_r <= krd_r[CODE_W+DEPTH_W-1:DEPTH_W];
        cur_dep_r  <= krd_r[DEPTH_W-1:0];
      end
      default: pos_r <= pos_r;
    endcase
  end

  assign st.in_last_acc = in_acc && in_tlast;
  assign st.cnt_ge2     = (cnt_r >= CW'(2));
  assign st.cnt_gt1     = (cnt_r > CW'(1));
  assign st.best_is_x   = best_x;
  assign st.i_zero      = (i_r == '0);
  assign st.pos_zero    = (pos_r == '0);
  assign st.parent_gt   = (hrd_r[WW-1:0] > y_r[WW-1:0]);
  assign st.is_leaf     = ((NW+1)'(cur_node_r) < (NW+1)'(n_r));
  assign st.out_acc     = out_acc;
  assign st.out_last    = olast_r;

  assign out_tdata = {4'd0, olen_r, ocode_r, osym_r};
  assign out_tlast = olast_r;
  assign out_tuser = oovf_r;

endmodule
`default_nettype wire

[rtl/core/huffman_code_builder_unit.sv]
`default_nettype none
// channel | direction | tdata (low bit up)                     | tlast       | tuser
// in_     | slave     | symbol[7:0], frequency[23:8]           | last_symbol | -
// out_    | master    | out_symbol, code_bits, code_length, pad | last_code   | overflow
//
// loading takes one symbol per cycle; the last one starts the build
// build, merges and walk share the one heap read port; a sift-down level
// steps through SDL, SDR and SDC, a sift-up level through INR and INC
// each code is held in the output register until taken; the walk waits on it
// synchronous active-low reset returns to loading with an empty set
module huffman_code_builder_unit #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
  parameter int FREQ_BITS   = hcb_pkg::FREQ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // symbol, frequency
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_symbol, code_bits, code_length, zero pad
  output logic             out_tlast,
  output logic             out_tuser   // overflow
);
  import hcb_pkg::*;

  cmd_t  cmd;
  stat_t st;

  hcb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  hcb_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .FREQ_BITS   (FREQ_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
